// ===== sv/awar_pkg.sv =====
// Shared types, codes and helpers for the analog window alarm relay block.
`timescale 1ns / 1ps
`default_nettype none

package awar_pkg;

  localparam logic [15:0] KEY_VALUE = 16'h55AA;
  localparam logic [3:0]  BASE_HITS = 4'd3;
  localparam logic [1:0]  ALARM_ENABLED = 2'd1;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ENABLE_KEY  = 3'd0,
    REG_CH0_LOW     = 3'd1,
    REG_CH0_HIGH    = 3'd2,
    REG_CH0_ACTION  = 3'd3,
    REG_CH1_LOW     = 3'd4,
    REG_CH1_HIGH    = 3'd5,
    REG_CH1_ACTION  = 3'd6,
    REG_INHIBIT     = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    RELAY_NONE  = 2'd0,
    RELAY_ON    = 2'd1,
    RELAY_OFF   = 2'd2,
    RELAY_PULSE = 2'd3
  } relay_cmd_e;

  // Action types from the action word
  localparam logic [2:0] ACT_PULSE  = 3'd0;
  localparam logic [2:0] ACT_ON     = 3'd1;
  localparam logic [2:0] ACT_OFF    = 3'd2;
  localparam logic [2:0] ACT_ON_REL = 3'd3;

  localparam logic [2:0] RELAY_NUM1 = 3'd1;
  localparam logic [2:0] RELAY_NUM2 = 3'd2;

  typedef struct packed {
    relay_cmd_e  cmd1;
    logic [3:0]  len1;
    relay_cmd_e  cmd2;
    logic [3:0]  len2;
  } relay_pair_t;

  // Apply one relay command; later commands to the same relay overwrite earlier ones.
  function automatic relay_pair_t drive_relay(relay_pair_t cur, logic inhibit,
                                              logic [2:0] num, relay_cmd_e cmd,
                                              logic [3:0] len);
    relay_pair_t r;
    logic [3:0]  l;
    r = cur;
    l = (cmd == RELAY_PULSE) ? len : 4'd0;
    if (!inhibit) begin
      if (num == RELAY_NUM1) begin
        r.cmd1 = cmd;
        r.len1 = l;
      end else if (num == RELAY_NUM2) begin
        r.cmd2 = cmd;
        r.len2 = l;
      end
    end
    return r;
  endfunction

  // Alarm action when an alarm fires.
  function automatic relay_pair_t fire_action(relay_pair_t cur, logic inhibit,
                                              logic [2:0] num, logic [2:0] kind,
                                              logic [3:0] len);
    relay_pair_t r;
    r = cur;
    case (kind)
      ACT_PULSE:  r = drive_relay(cur, inhibit, num, RELAY_PULSE, len);
      ACT_ON:     r = drive_relay(cur, inhibit, num, RELAY_ON, 4'd0);
      ACT_ON_REL: r = drive_relay(cur, inhibit, num, RELAY_ON, 4'd0);
      ACT_OFF:    r = drive_relay(cur, inhibit, num, RELAY_OFF, 4'd0);
      default:    r = cur;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/analog_window_alarm_relay_core.sv =====
// Window alarm on analog channels with relay commands: top level.
//
// Usage:
//   s_axis carries one sample beat: tuser = channel, tdata = sample and the
//   current second. m_axis returns one result beat per sample: relay commands
//   and pulse lengths, event count, latched alarm bits and the hit counter in
//   tdata, the skip flag in tuser. Configuration registers are written on the
//   cfg channel (index, data), which is always ready; write them only while no
//   sample is in flight.
//   An accepted sample passes through one input register, then one pass of
//   compare and update logic into the output register, to its result beat.
//   One sample is taken every cycle while the receiver keeps up; the
//   per-channel alarm state is updated as the sample moves into the output
//   register, so the next sample sees it at once.
//   Reset clears all configuration registers, hit counters, pause seconds and
//   alarm latches, and empties both registers. When the receiver stalls the
//   result beat holds, the input register fills, and then s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module analog_window_alarm_relay_core import awar_pkg::*; #(
  parameter int CHANNELS = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // sample stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [15:0] sample, [21:16] current_second
  input  wire logic [0:0]  s_axis_tuser,   // [0] channel
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [1:0] relay1_cmd, [5:2] relay1_pulse,
                                           // [7:6] relay2_cmd, [11:8] relay2_pulse,
                                           // [13:12] log_events, [15:14] min_alarms,
                                           // [17:16] max_alarms, [21:18] hit_count
  output logic [0:0]       m_axis_tuser,   // [0] skipped
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam logic [1:0] ChanCnt = 2'(CHANNELS);

  // configuration
  logic [15:0] key_q;
  logic [15:0] low_q  [2];
  logic [15:0] high_q [2];
  logic [15:0] act_q  [2];
  logic        inhibit_q;

  // per-channel state
  logic [3:0] hit_q   [CHANNELS];
  logic [5:0] pause_q [CHANNELS];
  logic       minl_q  [CHANNELS];
  logic       maxl_q  [CHANNELS];

  // input register
  logic        in_vld_q;
  logic        in_ch_q;
  logic [15:0] in_smp_q;
  logic [5:0]  in_sec_q;

  // output register
  logic        out_vld_q;
  logic [23:0] out_data_q;
  logic        out_skip_q;

  logic move;

  assign cfg_ready_o   = 1'b1;
  assign move          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || move;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_skip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= '0;
      low_q     <= '{default: '0};
      high_q    <= '{default: '0};
      act_q     <= '{default: '0};
      inhibit_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ENABLE_KEY: key_q     <= cfg_data_i;
        REG_CH0_LOW:    low_q[0]  <= cfg_data_i;
        REG_CH0_HIGH:   high_q[0] <= cfg_data_i;
        REG_CH0_ACTION: act_q[0]  <= cfg_data_i;
        REG_CH1_LOW:    low_q[1]  <= cfg_data_i;
        REG_CH1_HIGH:   high_q[1] <= cfg_data_i;
        REG_CH1_ACTION: act_q[1]  <= cfg_data_i;
        REG_INHIBIT:    inhibit_q <= cfg_data_i[0];
        default:        key_q     <= key_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_ch_q  <= s_axis_tuser[0];
      in_smp_q <= s_axis_tdata[15:0];
      in_sec_q <= s_axis_tdata[21:16];
    end
  end

  // ---------------------------------------------------------------------------
  // single-pass evaluation of the sample in the input register
  logic        absent;
  logic [3:0]  hc0;
  logic [5:0]  pause;
  logic        ml0, xl0;
  logic        skip;
  logic [15:0] w1, w2, wa;
  logic [15:0] vmin, vmax, hyst, rel_hi, rel_lo;
  logic [3:0]  fire_at, len;
  logic        hit_lo, hit_hi, fire_lo, fire_hi, release_now;
  logic [3:0]  hc1, hc2, hc3, hc_new;
  logic        ml1, xl1, ml2, xl2, ml_new, xl_new;
  logic [1:0]  events;
  relay_pair_t rly;
  logic [1:0]  mins, maxs;
  logic [3:0]  hit_out;

  always_comb begin
    absent = {1'b0, in_ch_q} >= ChanCnt;
    hc0    = '0;
    pause  = '0;
    ml0    = 1'b0;
    xl0    = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (in_ch_q == 1'(c)) begin
        hc0   = hit_q[c];
        pause = pause_q[c];
        ml0   = minl_q[c];
        xl0   = maxl_q[c];
      end
    end
    skip = (key_q != KEY_VALUE) || absent || (pause == in_sec_q);

    w1 = low_q[in_ch_q];
    w2 = high_q[in_ch_q];
    wa = act_q[in_ch_q];

    vmin    = {6'd0, w1[9:0]};
    fire_at = BASE_HITS + {1'b0, w1[12:10]};
    len     = {1'b0, w1[15:13]} + 4'd1;
    vmax    = {6'd0, w2[9:0]};
    hyst    = {10'd0, w2[15:10]};
    rel_hi  = vmax - hyst;   // wraps modulo 2^16
    rel_lo  = vmin + hyst;   // at most 1086, no wrap

    rly = '{cmd1: RELAY_NONE, len1: 4'd0, cmd2: RELAY_NONE, len2: 4'd0};

    // under-minimum check
    hit_lo  = (wa[7:6] == ALARM_ENABLED) && !ml0 && (in_smp_q < vmin);
    hc1     = hit_lo ? hc0 + 4'd1 : hc0;
    fire_lo = hit_lo && (hc1 == fire_at);
    ml1     = fire_lo ? 1'b1 : ml0;
    xl1     = fire_lo ? 1'b0 : xl0;
    if (fire_lo) begin
      rly = fire_action(rly, inhibit_q, wa[2:0], wa[5:3], len);
    end

    // at-or-over-maximum check, sees the latches after the minimum check
    hit_hi  = (wa[15:14] == ALARM_ENABLED) && !xl1 && (in_smp_q >= vmax);
    hc2     = hit_hi ? hc1 + 4'd1 : hc1;
    fire_hi = hit_hi && (hc2 == fire_at);
    xl2     = fire_hi ? 1'b1 : xl1;
    ml2     = fire_hi ? 1'b0 : ml1;
    if (fire_hi) begin
      rly = fire_action(rly, inhibit_q, wa[10:8], wa[13:11], len);
    end

    // release once back inside the band by at least the hysteresis
    release_now = (hc2 == fire_at) && (in_smp_q >= rel_lo) && (in_smp_q < rel_hi);
    hc3    = release_now ? 4'd0 : hc2;
    ml_new = release_now ? 1'b0 : ml2;
    xl_new = release_now ? 1'b0 : xl2;
    if (release_now && (wa[5:3] == ACT_ON_REL)) begin
      rly = drive_relay(rly, inhibit_q, wa[2:0], RELAY_OFF, 4'd0);
    end
    if (release_now && (wa[13:11] == ACT_ON_REL)) begin
      rly = drive_relay(rly, inhibit_q, wa[10:8], RELAY_OFF, 4'd0);
    end

    // drop a partial count once back inside the plain band
    hc_new = ((hc3 < fire_at) && (in_smp_q >= vmin) && (in_smp_q < vmax)) ? 4'd0 : hc3;

    events = 2'(fire_lo) + 2'(fire_hi);

    if (skip) begin
      rly    = '{cmd1: RELAY_NONE, len1: 4'd0, cmd2: RELAY_NONE, len2: 4'd0};
      events = 2'd0;
    end

    // latched alarm bits after this beat
    mins = '0;
    maxs = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (!skip && (in_ch_q == 1'(c))) begin
        mins[c] = ml_new;
        maxs[c] = xl_new;
      end else begin
        mins[c] = minl_q[c];
        maxs[c] = maxl_q[c];
      end
    end

    hit_out = absent ? 4'd0 : (skip ? hc0 : hc_new);
  end

  // advance channel state as the beat moves into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        hit_q[c]   <= '0;
        pause_q[c] <= '0;
        minl_q[c]  <= 1'b0;
        maxl_q[c]  <= 1'b0;
      end
    end else if (move && !skip) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (in_ch_q == 1'(c)) begin
          hit_q[c]  <= hc_new;
          minl_q[c] <= ml_new;
          maxl_q[c] <= xl_new;
          if (hit_lo || hit_hi) begin
            pause_q[c] <= in_sec_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (move) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_data_q <= {2'b00, hit_out, maxs, mins, events,
                     rly.len2, rly.cmd2, rly.len1, rly.cmd1};
      out_skip_q <= skip;
    end
  end

endmodule

`default_nettype wire
